/* hw/rtl/cifa_pkg.sv */
// package for the checked integer fold alu
// shared types, operation and status codes; used by all rtl files
`default_nettype none
package cifa_pkg;
  localparam int unsigned DataW = 64;
  localparam logic [DataW-1:0] ValMax = 64'h7fff_ffff_ffff_ffff;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
    OP_MOD = 3'd4, OP_POW = 3'd5, OP_MAX = 3'd6, OP_MIN = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_TYPE = 3'd1, ST_OVF = 3'd2, ST_DIV0 = 3'd3, ST_NEGEXP = 3'd4
  } status_t;

  // unit command: unsigned multiply or unsigned divide of magnitudes
  typedef struct packed {
    logic             start;
    logic             divide;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } unit_cmd_t;

  typedef struct packed {
    logic             done;
    logic             hi_nz;   // product exceeds 64 bits
    logic [DataW-1:0] lo;      // product low half or quotient
    logic [DataW-1:0] rem;
  } unit_rsp_t;
endpackage
`default_nettype wire

/* hw/rtl/cifa_muldiv.sv */
// shared iterative unsigned 64-bit multiply / divide unit, one bit a cycle
// depends on cifa_pkg
`default_nettype none
module cifa_muldiv (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cifa_pkg::unit_cmd_t cmd,
  output cifa_pkg::unit_rsp_t      rsp
);
  logic [5:0]   count;
  logic         busy;
  logic         done;
  logic         divide;
  logic [63:0]  b;
  logic [127:0] acc;   // multiply: {hi,lo}; divide: {rem,quotient}
  logic [64:0]  trial;

  assign trial = {acc[127:64], acc[63]} - {1'b0, b};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy   <= 1'b1;
        count  <= '0;
        divide <= cmd.divide;
        b      <= cmd.b;
        acc    <= {64'd0, cmd.a};
      end else if (busy) begin
        if (divide) begin
          if (!trial[64]) acc <= {trial[63:0], acc[62:0], 1'b1};
          else            acc <= {acc[126:0], 1'b0};
        end else begin
          // shift-add from lsb of multiplier held in acc low half
          acc <= {({1'b0, acc[127:64]} + (acc[0] ? {1'b0, b} : 65'd0)), acc[63:1]};
        end
        count <= count + 6'd1;
        if (count == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done  = done;
  assign rsp.lo    = acc[63:0];
  assign rsp.rem   = acc[127:64];
  assign rsp.hi_nz = |acc[127:64];
endmodule
`default_nettype wire

/* hw/rtl/checked_integer_fold_alu.sv */
// Folds a list of signed 64-bit words under one operation with overflow
// checks and returns one result word with a status on the word marked last.
// A first word, or one that only records an error, goes from idle to finish;
// add, sub, max and min pass through the step state; mul, div and mod also
// wait on one 64-step pass of the shared multiply/divide unit; pow waits one pass
// per multiplication, one per unit of the exponent, at most 63 before a base
// of magnitude two or more overflows. The block takes no word while it works
// on one. A result sits in an output register, so the next list can start
// while it waits; only a further last word stalls until that register drains.
// depends on cifa_pkg and cifa_muldiv
`default_nettype none
module checked_integer_fold_alu (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        valid_in,
  output logic             ready_in,
  input  wire logic [2:0]  func,
  input  wire logic signed [63:0] operand,
  input  wire logic        is_number,
  input  wire logic        first,
  input  wire logic        last,
  output logic             valid_out,
  input  wire logic        ready_out,
  output logic signed [63:0] value,
  output logic [2:0]       status
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_STEP = 4'b0010, S_WAIT = 4'b0100, S_FIN = 4'b1000
  } state_t;

  state_t            state;
  logic [63:0]       acc, b, n;
  logic [2:0]        op, err;
  logic              has_second, is_last, rneg;
  cifa_pkg::unit_cmd_t cmd;
  cifa_pkg::unit_rsp_t rsp;

  cifa_muldiv u_unit (.clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp));

  logic [63:0] sat_in, mag_a, mag_b, sum, dif;
  logic        a_neg, b_neg, neg_single, load_out;
  assign sat_in = (operand == 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0001 : operand;
  assign a_neg = acc[63];
  assign b_neg = b[63];
  assign mag_a = a_neg ? -acc : acc;
  assign mag_b = b_neg ? -b : b;
  assign sum   = acc + b;
  assign dif   = acc - b;

  assign ready_in = (state == S_IDLE);

  // single operand under sub is negated at the last word
  assign neg_single = (err == cifa_pkg::ST_OK) && (op == cifa_pkg::OP_SUB) && !has_second;
  assign load_out   = (state == S_FIN) && is_last && (!valid_out || ready_out);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      acc <= '0; op <= cifa_pkg::OP_ADD; err <= cifa_pkg::ST_OK;
      has_second <= 1'b0;
      cmd.start <= 1'b0;
    end else begin
      cmd.start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (valid_in) begin
            is_last <= last;
            b <= sat_in;
            if (first) begin
              op <= func; has_second <= 1'b0;
              acc <= is_number ? sat_in : 64'd0;
              err <= is_number ? cifa_pkg::ST_OK : cifa_pkg::ST_TYPE;
              state <= S_FIN;
            end else begin
              has_second <= 1'b1;
              if (!is_number) begin
                err <= cifa_pkg::ST_TYPE; state <= S_FIN;
              end else if (err != cifa_pkg::ST_OK) state <= S_FIN;
              else state <= S_STEP;
            end
          end
        end
        S_STEP: begin
          state <= S_FIN;
          case (op)
            cifa_pkg::OP_ADD: begin
              if (a_neg == b_neg && acc != 64'd0 && b != 64'd0 &&
                  (cifa_pkg::ValMax - mag_a) < mag_b)
                err <= cifa_pkg::ST_OVF;
              else acc <= sum;
            end
            cifa_pkg::OP_SUB: begin
              if (a_neg != b_neg && acc != 64'd0 && b != 64'd0 &&
                  (cifa_pkg::ValMax - mag_a) < mag_b)
                err <= cifa_pkg::ST_OVF;
              else acc <= dif;
            end
            cifa_pkg::OP_MAX: if ($signed(b) > $signed(acc)) acc <= b;
            cifa_pkg::OP_MIN: if ($signed(b) < $signed(acc)) acc <= b;
            cifa_pkg::OP_MUL: begin
              cmd.start <= 1'b1; cmd.divide <= 1'b0; cmd.a <= mag_a; cmd.b <= mag_b;
              rneg <= a_neg ^ b_neg; state <= S_WAIT;
            end
            cifa_pkg::OP_DIV, cifa_pkg::OP_MOD: begin
              if (b == 64'd0) err <= cifa_pkg::ST_DIV0;
              else begin
                cmd.start <= 1'b1; cmd.divide <= 1'b1; cmd.a <= mag_a; cmd.b <= mag_b;
                rneg <= (op == cifa_pkg::OP_DIV) ? (a_neg ^ b_neg) : a_neg;
                state <= S_WAIT;
              end
            end
            cifa_pkg::OP_POW: begin
              if (b_neg) err <= cifa_pkg::ST_NEGEXP;
              else if (acc == 64'd0) acc <= (b != 64'd0) ? 64'd0 : 64'd1;
              else if (mag_a == 64'd1) acc <= (a_neg && b[0]) ? -64'sd1 : 64'd1;
              else if (b == 64'd0) acc <= 64'd1;
              else begin
                // n counts the multiplies still to do, running power comes back from the unit
                n <= b;
                cmd.start <= 1'b1; cmd.divide <= 1'b0; cmd.a <= 64'd1; cmd.b <= mag_a;
                rneg <= 1'b0; state <= S_WAIT;
              end
            end
            default: ;
          endcase
        end
        S_WAIT: begin
          if (rsp.done) begin
            if (op == cifa_pkg::OP_DIV) begin
              acc <= rneg ? -rsp.lo : rsp.lo; state <= S_FIN;
            end else if (op == cifa_pkg::OP_MOD) begin
              acc <= rneg ? -rsp.rem : rsp.rem; state <= S_FIN;
            end else if (op == cifa_pkg::OP_MUL) begin
              if (rsp.hi_nz || rsp.lo[63]) err <= cifa_pkg::ST_OVF;
              else acc <= rneg ? -rsp.lo : rsp.lo;
              state <= S_FIN;
            end else begin
              // power: product magnitude of base times running power
              if (rsp.hi_nz || rsp.lo[63]) begin
                err <= cifa_pkg::ST_OVF; state <= S_FIN;
              end else if (n == 64'd1) begin
                acc <= (a_neg && b[0]) ? -rsp.lo : rsp.lo; state <= S_FIN;
              end else begin
                n <= n - 64'd1;
                cmd.start <= 1'b1; cmd.divide <= 1'b0; cmd.a <= rsp.lo; cmd.b <= mag_a;
              end
            end
          end
        end
        S_FIN: begin
          if (!is_last) state <= S_IDLE;
          else if (load_out) begin
            if (neg_single) begin
              acc <= -acc; has_second <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register, loads when empty or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (load_out) begin
      valid_out <= 1'b1;
      status <= err;
      if (neg_single) value <= -acc;
      else value <= (err == cifa_pkg::ST_OK) ? acc : 64'd0;
    end else if (ready_out) begin
      valid_out <= 1'b0;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    valid_out && !ready_out |=> valid_out && $stable(value) && $stable(status))
    else $error("output word changed while waiting");
  a_status_value: assert property (@(posedge clk) disable iff (rst)
    valid_out && status != cifa_pkg::ST_OK |-> value == 64'd0)
    else $error("value not zero on error");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !ready_in) else $error("ready while busy");
endmodule
`default_nettype wire

/* dv/checked_integer_fold_alu_tb.sv */
// testbench for checked_integer_fold_alu: directed and random operand lists
// checked result by result against an in-bench fold predictor; uses cifa_pkg
`default_nettype none
module checked_integer_fold_alu_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cifa_pkg::*;

  localparam longint VMax = 64'sh7fff_ffff_ffff_ffff;
  localparam longint MinBits = 64'sh8000_0000_0000_0000;
  localparam int CycleLimit = 25000000;
  localparam int DrainCycles = 5000;

  typedef struct {
    op_t    func;
    longint operand;
    bit     is_number;
    bit     first;
    bit     last;
  } fold_word_t;

  typedef struct {
    longint  value;
    status_t status;
  } fold_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid_in = 1'b0;
  logic ready_in;
  logic [2:0] func = '0;
  logic signed [63:0] operand = '0;
  logic is_number = 1'b0;
  logic first = 1'b0;
  logic last = 1'b0;
  logic valid_out;
  logic ready_out = 1'b0;
  logic signed [63:0] value;
  logic [2:0] status;

  checked_integer_fold_alu uut (
    .clk(clk), .rst(rst), .valid_in(valid_in), .ready_in(ready_in),
    .func(func), .operand(operand), .is_number(is_number), .first(first),
    .last(last), .valid_out(valid_out), .ready_out(ready_out),
    .value(value), .status(status)
  );

  always #2 clk = ~clk;

  fold_word_t   pending_words[$];
  fold_result_t expected_results[$];
  fold_word_t   cur_word;
  int words_sent = 0;
  int total_words = 1;
  int mismatches = 0;
  int cycles = 0;
  int hold_cycles = 0;
  bit hold_done = 1'b0;

  // predictor state
  longint  acc = 0;
  op_t     acc_op = OP_ADD;
  status_t acc_err = ST_OK;
  bit      acc_second = 1'b0;

  function automatic longint mag(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic status_t fold_step(longint a, longint b, output longint res);
    longint r;
    longint n;
    int guard;
    res = a;
    case (acc_op)
      OP_ADD: begin
        if (((a > 0 && b > 0) || (a < 0 && b < 0)) && (VMax - mag(a)) < mag(b))
          return ST_OVF;
        res = a + b;
      end
      OP_SUB: begin
        if (((a > 0 && b < 0) || (a < 0 && b > 0)) && (VMax - mag(a)) < mag(b))
          return ST_OVF;
        res = a - b;
      end
      OP_MUL: begin
        if (b != 0 && mag(a) > VMax / mag(b)) return ST_OVF;
        res = a * b;
      end
      OP_DIV: begin
        if (b == 0) return ST_DIV0;
        res = a / b;
      end
      OP_MOD: begin
        if (b == 0) return ST_DIV0;
        res = a % b;
      end
      OP_POW: begin
        if (b < 0) return ST_NEGEXP;
        if (a == 0) begin
          res = (b != 0) ? 0 : 1;
        end else if (a == 1 || a == -1) begin
          res = (a == -1 && b[0]) ? -1 : 1;
        end else begin
          r = 1;
          n = b;
          guard = 0;
          while (n > 0 && guard < 64) begin
            if (mag(r) > VMax / mag(a)) return ST_OVF;
            r = r * a;
            n--;
            guard++;
          end
          res = r;
        end
      end
      OP_MAX: res = a > b ? a : b;
      default: res = a < b ? a : b;
    endcase
    return ST_OK;
  endfunction

  task automatic predict_fold(fold_word_t w);
    longint opnd;
    longint r;
    status_t st;
    fold_result_t er;
    opnd = (w.operand == MinBits) ? -VMax : w.operand;
    if (w.first) begin
      acc_op = w.func;
      acc_second = 1'b0;
      acc = w.is_number ? opnd : 0;
      acc_err = w.is_number ? ST_OK : ST_TYPE;
    end else begin
      acc_second = 1'b1;
      if (!w.is_number) begin
        acc_err = ST_TYPE;
      end else if (acc_err == ST_OK) begin
        st = fold_step(acc, opnd, r);
        if (st != ST_OK) acc_err = st;
        else acc = r;
      end
    end
    if (w.last) begin
      if (acc_err == ST_OK && acc_op == OP_SUB && !acc_second) begin
        acc = -acc;
        acc_second = 1'b1;
      end
      er.value = (acc_err == ST_OK) ? acc : 0;
      er.status = acc_err;
      expected_results.push_back(er);
    end
  endtask

  function automatic int send_idle_pct();
    if (words_sent < total_words / 3) return 28;
    if (words_sent < 2 * total_words / 3) return 61;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (words_sent < total_words / 3) return 61;
    if (words_sent < 2 * total_words / 3) return 28;
    return 0;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      valid_in <= 1'b0;
    end else begin
      if (valid_in && ready_in) begin
        predict_fold(cur_word);
        words_sent++;
      end
      if (!valid_in || ready_in) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
          cur_word = pending_words.pop_front();
          func <= cur_word.func;
          operand <= cur_word.operand;
          is_number <= cur_word.is_number;
          first <= cur_word.first;
          last <= cur_word.last;
          valid_in <= 1'b1;
        end else begin
          valid_in <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    fold_result_t er;
    if (rst) begin
      ready_out <= 1'b0;
    end else begin
      if (valid_out && ready_out) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result value=%0d status=%0d", value, status);
        end else begin
          er = expected_results.pop_front();
          if (value !== er.value || status !== er.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                       er.value, er.status, value, status);
          end
        end
      end
      if (!hold_done && words_sent >= 300) begin
        hold_done <= 1'b1;
        hold_cycles <= 400;
        ready_out <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        ready_out <= 1'b0;
      end else begin
        ready_out <= ($urandom_range(99) >= recv_idle_pct());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic longint rnd_operand();
    case ($urandom_range(9))
      0: return 0;
      1: return 1;
      2: return -1;
      3: return VMax;
      4: return -VMax;
      5: return MinBits;
      6: return $signed($urandom_range(200)) - 100;
      7, 8: return {$urandom, $urandom};
      default: return $signed({{32{1'b0}}, $urandom}) - 64'sd2147483648;
    endcase
  endfunction

  // exponents are mostly 0 to 12, some negative, some 60 to 70 or any operand
  function automatic longint rnd_exponent();
    case ($urandom_range(19))
      0: return -$signed($urandom_range(5, 1));
      1: return $urandom_range(70, 60);
      2: return rnd_operand();
      default: return $urandom_range(12);
    endcase
  endfunction

  task automatic add_word(op_t f, longint v, bit num, bit fs, bit ls);
    fold_word_t w;
    w.func = f;
    w.operand = v;
    w.is_number = num;
    w.first = fs;
    w.last = ls;
    pending_words.push_back(w);
  endtask

  task automatic add_list(op_t f, int len);
    longint v;
    for (int i = 0; i < len; i++) begin
      if (i == 0 || f != OP_POW) v = rnd_operand();
      else v = rnd_exponent();
      if (f == OP_POW && i == 0 && $urandom_range(1)) v = $signed($urandom_range(10)) - 5;
      add_word(($urandom_range(3) == 0 || i == 0) ? f : op_t'($urandom_range(7)),
               v, $urandom_range(19) != 0, i == 0, i == len - 1);
    end
  endtask

  initial begin
    // no open list after reset: folds onto accumulator zero under add
    add_word(OP_MUL, 5, 1, 0, 0);
    add_word(OP_MAX, 7, 1, 0, 1);
    add_word(OP_ADD, VMax, 1, 1, 0);
    add_word(OP_ADD, 1, 1, 0, 1);
    add_word(OP_SUB, -VMax, 1, 1, 1);
    add_word(OP_SUB, MinBits, 1, 1, 1);
    add_word(OP_MUL, 64'sd4294967296, 1, 1, 0);
    add_word(OP_MUL, 64'sd4294967296, 1, 0, 1);
    add_word(OP_DIV, -VMax, 1, 1, 0);
    add_word(OP_DIV, 0, 1, 0, 1);
    add_word(OP_MOD, -17, 1, 1, 0);
    add_word(OP_MOD, 5, 1, 0, 1);
    add_word(OP_POW, 0, 1, 1, 0);
    add_word(OP_POW, 0, 1, 0, 1);
    add_word(OP_POW, -1, 1, 1, 0);
    add_word(OP_POW, VMax, 1, 0, 1);
    add_word(OP_POW, 2, 1, 1, 0);
    add_word(OP_POW, 63, 1, 0, 1);
    add_word(OP_POW, 3, 1, 1, 0);
    add_word(OP_POW, -2, 1, 0, 1);
    // first mark while open drops the open list
    add_word(OP_MIN, 9, 1, 1, 0);
    add_word(OP_MAX, -4, 1, 1, 0);
    add_word(OP_MAX, 0, 0, 0, 0);
    add_word(OP_MAX, 0, 1, 0, 1);
    add_word(OP_MIN, -3, 1, 1, 1);
    while (pending_words.size() < 1250) begin
      if ($urandom_range(99) < 85)
        add_list(op_t'($urandom_range(7)), $urandom_range(5, 1));
      else
        add_word(op_t'($urandom_range(7)), rnd_operand(), $urandom_range(1),
                 $urandom_range(1), $urandom_range(1));
    end
    total_words = pending_words.size();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (pending_words.size() == 0);
    @(posedge clk);
    wait (!valid_in);
    wait (expected_results.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
